@@ rtl/gda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg
// Types, constants and calendar helper functions for the date-advance core.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int C_DAY_W   = 5;
    localparam int C_MON_W   = 4;
    localparam int C_YEAR_W  = 14;
    localparam int C_CNT_W   = 16;
    localparam int C_ACC_W   = 17;
    localparam int C_Q_W     = 8;   // year / 100, at most 163
    localparam int C_R_W     = 7;   // year % 100
    localparam int C_WDAY_W  = 3;

    localparam logic [C_YEAR_W-1:0] C_MIN_YEAR_RST = 14'd1900;
    localparam logic [C_YEAR_W-1:0] C_MAX_YEAR_RST = 14'd2100;

    localparam logic [C_MON_W-1:0] C_MON_JAN = 4'd1;
    localparam logic [C_MON_W-1:0] C_MON_FEB = 4'd2;
    localparam logic [C_MON_W-1:0] C_MON_MAR = 4'd3;
    localparam logic [C_MON_W-1:0] C_MON_DEC = 4'd12;

    localparam logic [C_ACC_W-1:0] C_CENTURY = 17'd100;
    localparam logic [C_ACC_W-1:0] C_WEEK    = 17'd7;
    localparam logic [C_R_W-1:0]   C_R_LAST  = 7'd99;

    // Register indexes on the configuration port
    localparam logic C_REG_MIN_YEAR = 1'b0;
    localparam logic C_REG_MAX_YEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVZ,   // split the congruence year into century and remainder
        S_MOD7,   // reduce the congruence sum modulo 7
        S_DIVY,   // split the input year into century and remainder
        S_WALK,   // advance one month per cycle
        S_LOAD    // hand the result to the output register
    } t_state;

    // Leap year from the year's residues: rem = y % 100, cen = y / 100
    function automatic logic is_leap(input logic [C_R_W-1:0] rem,
                                     input logic [C_Q_W-1:0] cen);
        is_leap = (rem[1:0] == 2'b00) && ((rem != '0) || (cen[1:0] == 2'b00));
    endfunction

    // Month length; codes outside 1..12 take 31 days
    function automatic logic [C_DAY_W-1:0] month_len(input logic [C_MON_W-1:0] m,
                                                     input logic leap);
        case (m)
            4'd2:                   month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            default:                month_len = 5'd31;
        endcase
    endfunction

    // floor(13 * (m + 1) / 5) for the shifted month 3..15
    function automatic logic [5:0] zeller_mterm(input logic [C_MON_W-1:0] m);
        case (m)
            4'd3:    zeller_mterm = 6'd10;
            4'd4:    zeller_mterm = 6'd13;
            4'd5:    zeller_mterm = 6'd15;
            4'd6:    zeller_mterm = 6'd18;
            4'd7:    zeller_mterm = 6'd20;
            4'd8:    zeller_mterm = 6'd23;
            4'd9:    zeller_mterm = 6'd26;
            4'd10:   zeller_mterm = 6'd28;
            4'd11:   zeller_mterm = 6'd31;
            4'd12:   zeller_mterm = 6'd33;
            4'd13:   zeller_mterm = 6'd36;
            4'd14:   zeller_mterm = 6'd39;
            4'd15:   zeller_mterm = 6'd41;
            default: zeller_mterm = 6'd0;
        endcase
    endfunction

endpackage

@@ rtl/gregorian_date_add_days_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Gregorian date advance with input-date validity check and weekday.
// ----------------------------------------------------------------------------
// One transfer in on the slave side carries a date and a day count; one
// transfer out carries the date that many days later, the weekday of the input
// date (0 Saturday .. 6 Friday) and a validity flag on m_axis_tuser. Every
// loop runs through a single 17-bit subtract-and-compare unit, one step per
// clock: the congruence year is split by repeated subtraction of 100, the
// weekday sum is reduced by repeated subtraction of 7, the input year is
// split the same way, and then the date walks one month per cycle. With zero
// days to add the walk is skipped. s_axis_tready is high only while the core
// is idle; the finished result sits in an output register, so the next item
// is taken while the previous result waits. An overlong day rolls into the
// following month, and month codes outside 1..12 count as 31 days. The year
// wraps at 14 bits. min_year (address 0) and max_year (address 4) set the
// window of the validity check; write them only while the core is idle.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core
    import gda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: [4:0] day, [8:5] month, [22:9] year, [38:23] days_to_add
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // Master stream: [4:0] new_day, [8:5] new_month, [22:9] new_year,
    // [25:23] weekday
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    // tuser: [0] input_valid
    output logic        m_axis_tuser,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [C_ACC_W-1:0]    r_acc,   n_acc;     // working value of the shared unit
    logic [C_Q_W-1:0]      r_q,     n_q;       // quotient, later year / 100
    logic [C_R_W-1:0]      r_r,     n_r;       // year % 100 during the walk
    logic [C_DAY_W-1:0]    r_day_in;
    logic [C_MON_W-1:0]    r_mon_in;
    logic [C_YEAR_W-1:0]   r_year_in;
    logic [C_CNT_W-1:0]    r_cnt;
    logic [C_DAY_W-1:0]    r_d,     n_d;
    logic [C_MON_W-1:0]    r_m,     n_m;
    logic [C_YEAR_W-1:0]   r_y,     n_y;
    logic [C_WDAY_W-1:0]   r_wday,  n_wday;
    logic                  r_valid, n_valid;

    logic [C_DAY_W-1:0]    r_o_day;
    logic [C_MON_W-1:0]    r_o_mon;
    logic [C_YEAR_W-1:0]   r_o_year;
    logic [C_WDAY_W-1:0]   r_o_wday;
    logic                  r_o_valid;
    logic                  r_m_valid, n_m_valid;

    logic [C_YEAR_W-1:0]   r_min_year;
    logic [C_YEAR_W-1:0]   r_max_year;

    // ------------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------------
    logic                  w_in_xfer;
    logic                  w_out_load;
    logic [C_ACC_W-1:0]    w_sub_b;
    logic [C_ACC_W-1:0]    w_diff;
    logic                  w_borrow;
    logic [C_MON_W-1:0]    w_zmon;      // month shifted for the congruence
    logic [C_YEAR_W-1:0]   w_zyear;     // year used by the congruence
    logic [10:0]           w_zsum;
    logic [C_DAY_W-1:0]    w_walk_len;
    logic [C_DAY_W-1:0]    w_in_len;
    logic                  w_cfg_wr;

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // Shared unit: subtract and compare. A borrow ends every loop.
    // ------------------------------------------------------------------------
    assign {w_borrow, w_diff} = {1'b0, r_acc} - {1'b0, w_sub_b};

    // January and February belong to the previous year in the congruence.
    // The year seeds the first split at the accepting edge, so take it
    // straight from the incoming transfer.
    always_comb begin
        if (r_mon_in < C_MON_MAR) begin
            w_zmon = r_mon_in + C_MON_DEC;
        end else begin
            w_zmon = r_mon_in;
        end
        if (s_axis_tdata[8:5] < C_MON_MAR) begin
            w_zyear = s_axis_tdata[22:9] - C_YEAR_W'(1);
        end else begin
            w_zyear = s_axis_tdata[22:9];
        end
    end

    // d + 13(m+1)/5 + k + k/4 + j/4 + 5j with k, j from the finished split
    assign w_zsum = 11'(r_day_in) + 11'(zeller_mterm(w_zmon)) + 11'(r_acc[C_R_W-1:0])
                  + 11'(r_acc[C_R_W-1:2]) + 11'(r_q[C_Q_W-1:2])
                  + 11'({r_q, 2'b00}) + 11'(r_q);

    // Length of the month being walked and of the input month
    assign w_walk_len = month_len(r_m, is_leap(r_r, r_q));
    assign w_in_len   = month_len(r_mon_in, is_leap(r_acc[C_R_W-1:0], r_q));

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_DIVZ;
            end
            S_DIVZ: begin
                if (w_borrow) n_state = S_MOD7;
            end
            S_MOD7: begin
                if (w_borrow) n_state = S_DIVY;
            end
            S_DIVY: begin
                if (w_borrow) n_state = (r_cnt == '0) ? S_LOAD : S_WALK;
            end
            S_WALK: begin
                if (w_borrow) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs (handshake and operand of the shared unit)
    // ------------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        w_sub_b       = C_CENTURY;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_DIVZ: w_sub_b = C_CENTURY;
            S_MOD7: w_sub_b = C_WEEK;
            S_DIVY: w_sub_b = C_CENTURY;
            S_WALK: w_sub_b = C_ACC_W'(w_walk_len);
            S_LOAD: w_out_load = !r_m_valid || m_axis_tready;
            default: w_sub_b = C_CENTURY;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------------
    always_comb begin
        n_acc   = r_acc;
        n_q     = r_q;
        n_r     = r_r;
        n_d     = r_d;
        n_m     = r_m;
        n_y     = r_y;
        n_wday  = r_wday;
        n_valid = r_valid;
        case (r_state)
            S_IDLE: begin
                // Start the split of the congruence year
                n_acc = C_ACC_W'(w_zyear);
                n_q   = '0;
            end
            S_DIVZ: begin
                if (!w_borrow) begin
                    n_acc = w_diff;
                    n_q   = r_q + C_Q_W'(1);
                end else begin
                    n_acc = C_ACC_W'(w_zsum);
                end
            end
            S_MOD7: begin
                if (!w_borrow) begin
                    n_acc = w_diff;
                end else begin
                    n_wday = r_acc[C_WDAY_W-1:0];
                    n_acc  = C_ACC_W'(r_year_in);
                    n_q    = '0;
                end
            end
            S_DIVY: begin
                if (!w_borrow) begin
                    n_acc = w_diff;
                    n_q   = r_q + C_Q_W'(1);
                end else begin
                    n_r     = r_acc[C_R_W-1:0];
                    n_valid = (r_mon_in >= C_MON_JAN) && (r_mon_in <= C_MON_DEC)
                           && (r_year_in >= r_min_year) && (r_year_in <= r_max_year)
                           && (r_day_in != '0) && (r_day_in <= w_in_len);
                    n_d     = r_day_in;
                    n_m     = r_mon_in;
                    n_y     = r_year_in;
                    // Walk works on count + day - 1 against the month length
                    n_acc   = C_ACC_W'(r_cnt) + C_ACC_W'(r_day_in) - C_ACC_W'(1);
                end
            end
            S_WALK: begin
                if (!w_borrow) begin
                    // Leave this month: drop its length, go to the first of the next
                    n_acc = w_diff;
                    if (r_m >= C_MON_DEC) begin
                        n_m = C_MON_JAN;
                        if (r_y == '1) begin
                            n_y = '0;
                            n_r = '0;
                            n_q = '0;
                        end else begin
                            n_y = r_y + C_YEAR_W'(1);
                            if (r_r == C_R_LAST) begin
                                n_r = '0;
                                n_q = r_q + C_Q_W'(1);
                            end else begin
                                n_r = r_r + C_R_W'(1);
                            end
                        end
                    end else begin
                        n_m = r_m + C_MON_W'(1);
                    end
                end else begin
                    n_d = r_acc[C_DAY_W-1:0] + C_DAY_W'(1);
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // Output register: load on hand-off, clear when the transfer completes
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_out_load) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == C_REG_MAX_YEAR) ? 32'(r_max_year) : 32'(r_min_year);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_valid  <= 1'b0;
            r_min_year <= C_MIN_YEAR_RST;
            r_max_year <= C_MAX_YEAR_RST;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (w_cfg_wr) begin
                if (paddr[2] == C_REG_MIN_YEAR) begin
                    r_min_year <= pwdata[C_YEAR_W-1:0];
                end else begin
                    r_max_year <= pwdata[C_YEAR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_q     <= n_q;
        r_r     <= n_r;
        r_d     <= n_d;
        r_m     <= n_m;
        r_y     <= n_y;
        r_wday  <= n_wday;
        r_valid <= n_valid;
        if (w_in_xfer) begin
            r_day_in  <= s_axis_tdata[4:0];
            r_mon_in  <= s_axis_tdata[8:5];
            r_year_in <= s_axis_tdata[22:9];
            r_cnt     <= s_axis_tdata[38:23];
        end
        if (w_out_load) begin
            r_o_day   <= r_d;
            r_o_mon   <= r_m;
            r_o_year  <= r_y;
            r_o_wday  <= r_wday;
            r_o_valid <= r_valid;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_o_wday, r_o_year, r_o_mon, r_o_day};
    assign m_axis_tuser  = r_o_valid;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Year residues track the walked year
    a_residue_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_y == C_YEAR_W'(r_q * 100 + r_r)))
        else $error("year residues out of step with walked year");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_r <= C_R_LAST))
        else $error("year remainder beyond 99");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_DIVZ))
        else $error("accepted item did not start the sequence");

    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (m_axis_tvalid && (r_state == S_IDLE)))
        else $error("result hand-off lost");

    a_walk_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && w_borrow) |=> (r_d != '0))
        else $error("walk ended on day zero");

endmodule
